>>> src/rpp_pkg.sv
`default_nettype none

package rpp_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int ANG_W   = 17;
    localparam int Z_W     = 32;

    // Integer bits of the CORDIC words above the guard bits: Q16.16 range, the
    // 33-bit offset, growth through the rotation and the sign
    localparam int XY_HEAD_BITS = 35;

    // Packed stream widths
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 72;

    // Angle reduction, Q9.7 degrees
    localparam int                 RES_W        = 14;
    localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
    localparam logic [15:0]        QUARTER_TURN = 16'd11520;

    // Quarter-turn codes
    localparam logic [1:0] QTR_NONE  = 2'd0;
    localparam logic [1:0] QTR_ONE   = 2'd1;
    localparam logic [1:0] QTR_HALF  = 2'd2;
    localparam logic [1:0] QTR_THREE = 2'd3;

    // Degrees to Q30 radians: z = floor((r * PI_Q32 + Z_DIV / 2) / Z_DIV),
    // split as r * PI_HI + floor((r * PI_LO + Z_RND) / Z_DIV)
    localparam int          ANG_BITS    = 30;
    localparam longint      PI_Q32      = 64'sd13493037705;
    localparam int          Z_ODD       = 45;
    localparam int          Z_PRE_SHIFT = 11;
    localparam longint      Z_DIV       = longint'(Z_ODD) << Z_PRE_SHIFT;
    localparam logic [17:0] PI_HI       = 18'(PI_Q32 / Z_DIV);
    localparam logic [16:0] PI_LO       = 17'(PI_Q32 % Z_DIV);
    localparam logic [15:0] Z_RND       = 16'(Z_DIV / 2);
    localparam int          ZLO_W       = 30;
    localparam int          ZHI_W       = 31;
    localparam int          ZV_W        = ZLO_W - Z_PRE_SHIFT;
    localparam int          RECIP_SHIFT = 25;
    localparam logic [19:0] RECIP       =
        20'(((longint'(1) << RECIP_SHIFT) + Z_ODD - 1) / Z_ODD);
    localparam int          ZVM_W       = ZV_W + 20;

    localparam logic [31:0] QUARTER_PI_Q30 = 32'd843314857;
    localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629714;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    // Integer square root, elaboration only
    function automatic logic [63:0] rpp_isqrt(input logic [63:0] n);
        logic [63:0] rem_v;
        logic [63:0] res_v;
        logic [63:0] bit_v;
        rem_v = n;
        res_v = 64'd0;
        bit_v = 64'd1 << 62;
        while (bit_v > rem_v) bit_v = bit_v >> 2;
        while (bit_v != 64'd0) begin
            if (rem_v >= res_v + bit_v) begin
                rem_v = rem_v - (res_v + bit_v);
                res_v = (res_v >> 1) + bit_v;
            end else begin
                res_v = res_v >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res_v;
    endfunction

    // Root of the accumulated CORDIC gain product, scaled by 2^30
    function automatic logic [63:0] rpp_gain_root(input int steps);
        logic [63:0] p;
        p = 64'd1 << 30;
        for (int i = 0; i < steps; i++) begin
            p = p + (p >> (2 * i));
        end
        return rpp_isqrt(p << 30);
    endfunction

    // Shift-subtract quotient, elaboration only
    function automatic logic [63:0] rpp_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Arctangent of 2^-i in Q30 radians, from its series in Q60
    function automatic logic [31:0] rpp_atan(input int i);
        logic signed [63:0] sum;
        logic [63:0]        t;
        int                 k;
        if (i == 0) return QUARTER_PI_Q30;
        sum = 64'sd0;
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
            t = rpp_udiv(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
            if (k[0]) sum = sum - signed'(t);
            else sum = sum + signed'(t);
        end
        return 32'((sum + (64'sd1 <<< 29)) >>> 30);
    endfunction

endpackage

`default_nettype wire

>>> src/rpp_prep.sv
`default_nettype none

module rpp_prep import rpp_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16,
    parameter int DATA_W       = 51
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] point_x,
    input  wire logic signed [COORD_W-1:0] point_y,
    input  wire logic signed [COORD_W-1:0] pivot_x,
    input  wire logic signed [COORD_W-1:0] pivot_y,
    input  wire logic signed [ANG_W-1:0]   angle_deg,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [DATA_W-1:0]       x_out,
    output logic signed [DATA_W-1:0]       y_out,
    output logic signed [Z_W-1:0]          z_out,
    output logic signed [COORD_W-1:0]      cx_out,
    output logic signed [COORD_W-1:0]      cy_out
);

    localparam logic [63:0]        GAIN_ROOT = rpp_gain_root(CORDIC_STEPS);
    localparam logic [63:0]        GAIN_Q30  = (64'd1 << 60) / GAIN_ROOT;
    localparam logic signed [31:0] GAIN      = signed'(GAIN_Q30[31:0]);
    localparam int                 SH_IN     = ANG_BITS - FRAC_BITS;
    localparam logic signed [63:0] RND_IN    = 64'sd1 <<< (SH_IN - 1);

    // Stage valid bits and the ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: offsets and angle reduction
    logic signed [32:0]        dx1_reg, dy1_reg, dx_next, dy_next;
    logic [1:0]                q1_reg, q_next;
    logic [RES_W-1:0]          r1_reg, r_next;
    logic signed [COORD_W-1:0] cx1_reg, cy1_reg;
    logic signed [17:0]        a0, a1, a2, am;
    logic [15:0]               m;

    always_comb begin
        dx_next = 33'(point_x) - 33'(pivot_x);
        dy_next = 33'(point_y) - 33'(pivot_y);
        a0 = 18'(angle_deg);
        a1 = a0[17] ? a0 + FULL_TURN : a0;
        a2 = a1[17] ? a1 + FULL_TURN : a1;
        am = (a2 >= FULL_TURN) ? a2 - FULL_TURN : a2;
        m  = am[15:0];
        if (m >= 16'(3 * QUARTER_TURN)) begin
            q_next = QTR_THREE;
            r_next = RES_W'(m - 16'(3 * QUARTER_TURN));
        end else if (m >= 16'(2 * QUARTER_TURN)) begin
            q_next = QTR_HALF;
            r_next = RES_W'(m - 16'(2 * QUARTER_TURN));
        end else if (m >= QUARTER_TURN) begin
            q_next = QTR_ONE;
            r_next = RES_W'(m - QUARTER_TURN);
        end else begin
            q_next = QTR_NONE;
            r_next = RES_W'(m);
        end
    end

    // Stage 2: gain products and angle partial products
    logic signed [63:0]        px2_reg, py2_reg, px_next, py_next;
    logic [ZLO_W-1:0]          zlo2_reg, zlo_next;
    logic [ZHI_W-1:0]          zhi2_reg, zhi_next;
    logic [ZLO_W-1:0]          zlo_prod;
    logic [ZHI_W-1:0]          zhi_prod;
    logic [1:0]                q2_reg;
    logic signed [COORD_W-1:0] cx2_reg, cy2_reg;

    always_comb begin
        px_next  = 64'(dx1_reg) * 64'(GAIN);
        py_next  = 64'(dy1_reg) * 64'(GAIN);
        zlo_prod = ZLO_W'(r1_reg) * ZLO_W'(PI_LO);
        zhi_prod = ZHI_W'(r1_reg) * ZHI_W'(PI_HI);
        zlo_next = zlo_prod + ZLO_W'(Z_RND);
        zhi_next = zhi_prod;
    end

    // Stage 3: round to the CORDIC scale, reciprocal product for the angle
    logic signed [DATA_W-1:0]  x3_reg, y3_reg, x3_next, y3_next;
    logic signed [63:0]        rx, ry;
    logic [ZVM_W-1:0]          vm3_reg, vm_next;
    logic [ZHI_W-1:0]          zhi3_reg;
    logic [1:0]                q3_reg;
    logic signed [COORD_W-1:0] cx3_reg, cy3_reg;

    always_comb begin
        rx      = px2_reg + RND_IN;
        ry      = py2_reg + RND_IN;
        x3_next = DATA_W'(rx >>> SH_IN);
        y3_next = DATA_W'(ry >>> SH_IN);
        vm_next = ZVM_W'(zlo2_reg[ZLO_W-1:Z_PRE_SHIFT]) * ZVM_W'(RECIP);
    end

    // Stage 4: quarter turns and the residual angle
    logic signed [DATA_W-1:0]  x4_reg, y4_reg, x4_next, y4_next;
    logic signed [Z_W-1:0]     z4_reg, z4_next;
    logic signed [COORD_W-1:0] cx4_reg, cy4_reg;

    always_comb begin
        z4_next = Z_W'({1'b0, zhi3_reg}) + Z_W'(vm3_reg[ZVM_W-1:RECIP_SHIFT]);
        case (q3_reg)
            QTR_NONE: begin
                x4_next = x3_reg;
                y4_next = y3_reg;
            end
            QTR_ONE: begin
                x4_next = -y3_reg;
                y4_next = x3_reg;
            end
            QTR_HALF: begin
                x4_next = -x3_reg;
                y4_next = -y3_reg;
            end
            QTR_THREE: begin
                x4_next = y3_reg;
                y4_next = -x3_reg;
            end
            default: begin
                x4_next = x3_reg;
                y4_next = y3_reg;
            end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Load payload where a beat moves in
    always_ff @(posedge aclk) begin
        if (in_valid && rdy1) begin
            dx1_reg <= dx_next;
            dy1_reg <= dy_next;
            q1_reg  <= q_next;
            r1_reg  <= r_next;
            cx1_reg <= pivot_x;
            cy1_reg <= pivot_y;
        end
        if (v1_reg && rdy2) begin
            px2_reg  <= px_next;
            py2_reg  <= py_next;
            zlo2_reg <= zlo_next;
            zhi2_reg <= zhi_next;
            q2_reg   <= q1_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
        end
        if (v2_reg && rdy3) begin
            x3_reg   <= x3_next;
            y3_reg   <= y3_next;
            vm3_reg  <= vm_next;
            zhi3_reg <= zhi2_reg;
            q3_reg   <= q2_reg;
            cx3_reg  <= cx2_reg;
            cy3_reg  <= cy2_reg;
        end
        if (v3_reg && rdy4) begin
            x4_reg  <= x4_next;
            y4_reg  <= y4_next;
            z4_reg  <= z4_next;
            cx4_reg <= cx3_reg;
            cy4_reg <= cy3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign x_out     = x4_reg;
    assign y_out     = y4_reg;
    assign z_out     = z4_reg;
    assign cx_out    = cx4_reg;
    assign cy_out    = cy4_reg;

    // Residual stays below a quarter turn in degrees and in radians
    a_res_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (r1_reg < RES_W'(QUARTER_TURN)))
        else $error("residual angle not below a quarter turn");

    a_z_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (!z4_reg[Z_W-1] && (z4_reg < HALF_PI_Q30)))
        else $error("residual radians out of range");

endmodule

`default_nettype wire

>>> src/rpp_cordic.sv
`default_nettype none

module rpp_cordic import rpp_pkg::*; #(
    parameter int STEPS  = 16,
    parameter int DATA_W = 51
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [DATA_W-1:0]  x_in,
    input  wire logic signed [DATA_W-1:0]  y_in,
    input  wire logic signed [Z_W-1:0]     z_in,
    input  wire logic signed [COORD_W-1:0] cx_in,
    input  wire logic signed [COORD_W-1:0] cy_in,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [DATA_W-1:0]       x_out,
    output logic signed [DATA_W-1:0]       y_out,
    output logic signed [COORD_W-1:0]      cx_out,
    output logic signed [COORD_W-1:0]      cy_out
);

    localparam logic signed [Z_W-1:0] ATAN_LAST = signed'(rpp_atan(STEPS - 1));
    localparam logic signed [Z_W-1:0] Z_BOUND   = Z_W'(2 * ATAN_LAST + STEPS);

    logic [STEPS:0]            rdy;
    logic [STEPS-1:0]          v_reg;
    logic [STEPS-1:0]          v_src;
    logic signed [DATA_W-1:0]  x_reg [STEPS];
    logic signed [DATA_W-1:0]  y_reg [STEPS];
    logic signed [Z_W-1:0]     z_reg [STEPS];
    logic signed [COORD_W-1:0] cx_reg [STEPS];
    logic signed [COORD_W-1:0] cy_reg [STEPS];
    logic signed [DATA_W-1:0]  x_src [STEPS];
    logic signed [DATA_W-1:0]  y_src [STEPS];
    logic signed [Z_W-1:0]     z_src [STEPS];
    logic signed [COORD_W-1:0] cx_src [STEPS];
    logic signed [COORD_W-1:0] cy_src [STEPS];

    assign rdy[STEPS] = out_ready;
    assign in_ready   = rdy[0];

    // One micro-rotation per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic signed [Z_W-1:0] ATAN = signed'(rpp_atan(k));

        logic signed [DATA_W-1:0] x_next, y_next;
        logic signed [Z_W-1:0]    z_next;

        if (k == 0) begin : g_head
            assign v_src[k]  = in_valid;
            assign x_src[k]  = x_in;
            assign y_src[k]  = y_in;
            assign z_src[k]  = z_in;
            assign cx_src[k] = cx_in;
            assign cy_src[k] = cy_in;
        end else begin : g_link
            assign v_src[k]  = v_reg[k-1];
            assign x_src[k]  = x_reg[k-1];
            assign y_src[k]  = y_reg[k-1];
            assign z_src[k]  = z_reg[k-1];
            assign cx_src[k] = cx_reg[k-1];
            assign cy_src[k] = cy_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        // Turn toward zero residual angle
        always_comb begin
            if (!z_src[k][Z_W-1]) begin
                x_next = x_src[k] - (y_src[k] >>> k);
                y_next = y_src[k] + (x_src[k] >>> k);
                z_next = z_src[k] - ATAN;
            end else begin
                x_next = x_src[k] + (y_src[k] >>> k);
                y_next = y_src[k] - (x_src[k] >>> k);
                z_next = z_src[k] + ATAN;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (v_src[k] && rdy[k]) begin
                x_reg[k]  <= x_next;
                y_reg[k]  <= y_next;
                z_reg[k]  <= z_next;
                cx_reg[k] <= cx_src[k];
                cy_reg[k] <= cy_src[k];
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign x_out     = x_reg[STEPS-1];
    assign y_out     = y_reg[STEPS-1];
    assign cx_out    = cx_reg[STEPS-1];
    assign cy_out    = cy_reg[STEPS-1];

    // Residual angle has converged after the last micro-rotation
    a_converged: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[STEPS-1] |-> ((z_reg[STEPS-1] <= Z_BOUND) && (z_reg[STEPS-1] >= -Z_BOUND)))
        else $error("CORDIC residual angle did not converge");

endmodule

`default_nettype wire

>>> src/rpp_post.sv
`default_nettype none

module rpp_post import rpp_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int DATA_W    = 51
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [DATA_W-1:0]  x_in,
    input  wire logic signed [DATA_W-1:0]  y_in,
    input  wire logic signed [COORD_W-1:0] cx_in,
    input  wire logic signed [COORD_W-1:0] cy_in,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [COORD_W-1:0]      rot_x,
    output logic signed [COORD_W-1:0]      rot_y,
    output logic                           saturated
);

    localparam int                       RW      = DATA_W - FRAC_BITS;
    localparam int                       SW      = RW + 1;
    localparam logic signed [DATA_W-1:0] RND_OUT = DATA_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0]     SAT_HI  = SW'(INT32_MAX);
    localparam logic signed [SW-1:0]     SAT_LO  = SW'(INT32_MIN);

    logic va_reg, vb_reg;
    logic rdya, rdyb;

    assign rdyb     = !vb_reg || out_ready;
    assign rdya     = !va_reg || rdyb;
    assign in_ready = rdya;

    // Stage A: drop the guard bits with rounding
    logic signed [DATA_W-1:0]  xa, ya;
    logic signed [RW-1:0]      xa_reg, ya_reg, xa_next, ya_next;
    logic signed [COORD_W-1:0] cxa_reg, cya_reg;

    always_comb begin
        xa      = x_in + RND_OUT;
        ya      = y_in + RND_OUT;
        xa_next = RW'(xa >>> FRAC_BITS);
        ya_next = RW'(ya >>> FRAC_BITS);
    end

    // Stage B: add the pivot back and clamp
    logic signed [SW-1:0]      sx, sy;
    logic signed [COORD_W-1:0] rx_reg, ry_reg, rx_next, ry_next;
    logic                      sat_reg, sat_next;

    always_comb begin
        sx       = SW'(xa_reg) + SW'(cxa_reg);
        sy       = SW'(ya_reg) + SW'(cya_reg);
        sat_next = 1'b0;
        if (sx > SAT_HI) begin
            rx_next  = INT32_MAX;
            sat_next = 1'b1;
        end else if (sx < SAT_LO) begin
            rx_next  = INT32_MIN;
            sat_next = 1'b1;
        end else begin
            rx_next = sx[COORD_W-1:0];
        end
        if (sy > SAT_HI) begin
            ry_next  = INT32_MAX;
            sat_next = 1'b1;
        end else if (sy < SAT_LO) begin
            ry_next  = INT32_MIN;
            sat_next = 1'b1;
        end else begin
            ry_next = sy[COORD_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (rdya) va_reg <= in_valid;
            if (rdyb) vb_reg <= va_reg;
        end
    end

    // Load payload where a beat moves in
    always_ff @(posedge aclk) begin
        if (in_valid && rdya) begin
            xa_reg  <= xa_next;
            ya_reg  <= ya_next;
            cxa_reg <= cx_in;
            cya_reg <= cy_in;
        end
        if (va_reg && rdyb) begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = vb_reg;
    assign rot_x     = rx_reg;
    assign rot_y     = ry_reg;
    assign saturated = sat_reg;

    // A clamp flag means at least one coordinate sits at a rail
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (vb_reg && sat_reg) |-> ((rx_reg == INT32_MAX) || (rx_reg == INT32_MIN) ||
                                 (ry_reg == INT32_MAX) || (ry_reg == INT32_MIN)))
        else $error("saturation flag without a clamped coordinate");

endmodule

`default_nettype wire

>>> src/rotate_point_about_pivot.sv
// Channel   Dir  tdata fields (low bit up)                                  Beat
// --------  ---  ---------------------------------------------------------  ----------
// s_        in   point_x, point_y, pivot_x, pivot_y, angle_deg, zero pad    one point
// m_        out  rot_x, rot_y, saturated, zero pad                          one result
//
// One beat per clock in and out while m_tready is high. The pipe has four
// set-up stages, one stage per CORDIC micro-rotation, then rounding and the
// pivot add with clamp.
// Reset clears the stage valid bits only; no state carries between points.
// Each stage holds its beat while the stage after it is full and blocked, so
// bubbles close up; s_tready falls only when every stage is full and m_tready is low.

`default_nettype none

module rotate_point_about_pivot import rpp_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // point_x[31:0], point_y[63:32], pivot_x[95:64], pivot_y[127:96],
    // angle_deg[144:128], zero [151:145]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // rot_x[31:0], rot_y[63:32], saturated[64], zero [71:65]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int DATA_W = FRAC_BITS + XY_HEAD_BITS;

    logic signed [COORD_W-1:0] point_x, point_y, pivot_x, pivot_y;
    logic signed [ANG_W-1:0]   angle_deg;

    assign point_x   = s_tdata[31:0];
    assign point_y   = s_tdata[63:32];
    assign pivot_x   = s_tdata[95:64];
    assign pivot_y   = s_tdata[127:96];
    assign angle_deg = s_tdata[144:128];

    // Set-up stages to CORDIC
    logic                      p_valid, p_ready;
    logic signed [DATA_W-1:0]  p_x, p_y;
    logic signed [Z_W-1:0]     p_z;
    logic signed [COORD_W-1:0] p_cx, p_cy;

    // CORDIC to output stages
    logic                      c_valid, c_ready;
    logic signed [DATA_W-1:0]  c_x, c_y;
    logic signed [COORD_W-1:0] c_cx, c_cy;

    logic signed [COORD_W-1:0] rot_x, rot_y;
    logic                      saturated;

    rpp_prep #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .FRAC_BITS   (FRAC_BITS),
        .DATA_W      (DATA_W)
    ) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .point_x  (point_x),
        .point_y  (point_y),
        .pivot_x  (pivot_x),
        .pivot_y  (pivot_y),
        .angle_deg(angle_deg),
        .out_valid(p_valid),
        .out_ready(p_ready),
        .x_out    (p_x),
        .y_out    (p_y),
        .z_out    (p_z),
        .cx_out   (p_cx),
        .cy_out   (p_cy)
    );

    rpp_cordic #(
        .STEPS (CORDIC_STEPS),
        .DATA_W(DATA_W)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (p_valid),
        .in_ready (p_ready),
        .x_in     (p_x),
        .y_in     (p_y),
        .z_in     (p_z),
        .cx_in    (p_cx),
        .cy_in    (p_cy),
        .out_valid(c_valid),
        .out_ready(c_ready),
        .x_out    (c_x),
        .y_out    (c_y),
        .cx_out   (c_cx),
        .cy_out   (c_cy)
    );

    rpp_post #(
        .FRAC_BITS(FRAC_BITS),
        .DATA_W   (DATA_W)
    ) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (c_valid),
        .in_ready (c_ready),
        .x_in     (c_x),
        .y_in     (c_y),
        .cx_in    (c_cx),
        .cy_in    (c_cy),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .rot_x    (rot_x),
        .rot_y    (rot_y),
        .saturated(saturated)
    );

    // Pack the result beat
    assign m_tdata = {7'd0, saturated, rot_y, rot_x};

    // Input is refused only when the whole pipe is full behind a blocked output
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input refused while the pipeline has room");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpp_pkg::*;

    localparam int CORDIC_N = 16;
    localparam int FRAC_N   = 16;
    localparam int LIMIT    = 200000;

    localparam longint DEG_FULL    = 46080;
    localparam longint DEG_QUARTER = 11520;

    localparam logic signed [31:0] MAXC = INT32_MAX;
    localparam logic signed [31:0] MINC = INT32_MIN;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    // Sender idle and receiver stall, percent per cycle, one pair per phase
    localparam int IDLE_PCT  [4] = '{0, 71, 0, 8};
    localparam int STALL_PCT [4] = '{0, 0, 71, 8};

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [16:0] ang;
    } pt_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               sat;
    } rot_t;

    typedef struct packed {
        pt_t  pt;
        logic has_want;
        rot_t want;
    } dir_row_t;

    localparam rot_t NO_WANT = rot_t'(0);

    // Directed beats: point, pivot, angle; expected result where it is obvious
    localparam int DIR_N = 21;
    localparam dir_row_t DIRECTED [DIR_N] = '{
        // zero offset leaves the pivot in place
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
        '{'{MAXC, MINC, MAXC, MINC, 17'sd46080}, 1'b1, '{MAXC, MINC, 1'b0}},
        '{'{MINC, MAXC, MINC, MAXC, -17'sd46080}, 1'b1, '{MINC, MAXC, 1'b0}},
        '{'{ONE, -ONE, ONE, -ONE, 17'sh0FFFF}, 1'b1, '{ONE, -ONE, 1'b0}},
        // half turn of the widest offsets clamps both coordinates
        '{'{MINC, MINC, MAXC, MAXC, 17'sd23040}, 1'b1, '{MAXC, MAXC, 1'b1}},
        '{'{MAXC, MAXC, MINC, MINC, -17'sd23040}, 1'b1, '{MINC, MINC, 1'b1}},
        // unit offset through every quadrant and the turn boundaries
        '{'{ONE, 32'sd0, 32'sd0, 32'sd0, 17'sd0}, 1'b0, NO_WANT},
        '{'{ONE, 32'sd0, 32'sd0, 32'sd0, 17'sd11520}, 1'b0, NO_WANT},
        '{'{ONE, 32'sd0, 32'sd0, 32'sd0, 17'sd23040}, 1'b0, NO_WANT},
        '{'{ONE, 32'sd0, 32'sd0, 32'sd0, 17'sd34560}, 1'b0, NO_WANT},
        '{'{ONE, 32'sd0, 32'sd0, 32'sd0, -17'sd11520}, 1'b0, NO_WANT},
        '{'{ONE, 32'sd0, 32'sd0, 32'sd0, 17'sd46080}, 1'b0, NO_WANT},
        '{'{ONE, 32'sd0, 32'sd0, 32'sd0, -17'sd46080}, 1'b0, NO_WANT},
        // angles past a full turn wrap around; small steps either side of zero too
        '{'{ONE, ONE, 32'sd0, 32'sd0, 17'sh0FFFF}, 1'b0, NO_WANT},
        '{'{ONE, ONE, 32'sd0, 32'sd0, 17'sh10000}, 1'b0, NO_WANT},
        '{'{ONE, ONE, 32'sd0, 32'sd0, 17'sd1}, 1'b0, NO_WANT},
        '{'{ONE, ONE, 32'sd0, 32'sd0, -17'sd1}, 1'b0, NO_WANT},
        '{'{ONE, ONE, 32'sd0, 32'sd0, 17'sd46079}, 1'b0, NO_WANT},
        // extreme offsets and one small offset at other angles
        '{'{MAXC, MINC, MINC, MAXC, 17'sd5760}, 1'b0, NO_WANT},
        '{'{MINC, 32'sd0, MAXC, 32'sd0, 17'sd11520}, 1'b0, NO_WANT},
        '{'{32'sh0003_0000, -32'sh0002_0000, ONE, ONE, 17'sd3840}, 1'b0, NO_WANT}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // point_x, point_y, pivot_x, pivot_y, angle_deg, zero pad
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // rot_x, rot_y, saturated, zero pad
    logic [M_TDATA_W-1:0] m_tdata;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;

    longint gain_q30;
    longint arctan_q30 [CORDIC_N];
    rot_t   pending_rot [$];

    rotate_point_about_pivot #(
        .CORDIC_STEPS(CORDIC_N),
        .FRAC_BITS   (FRAC_N)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Round to nearest by adding half an LSB, then floor
    function automatic longint round_shift(input longint v, input int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp_coord(input longint v, inout logic sat);
        if (v > longint'(MAXC)) begin
            sat = 1'b1;
            return MAXC;
        end
        if (v < longint'(MINC)) begin
            sat = 1'b1;
            return MINC;
        end
        return 32'(v);
    endfunction

    // Expected rotated point: quarter turns exactly, residual by CORDIC
    function automatic rot_t rotate_about_pivot(input pt_t p);
        longint     m, r, z, x, y, t, xs, ys;
        logic [1:0] qtr;
        rot_t       res;
        m = longint'($signed(p.ang)) % DEG_FULL;
        if (m < 0) m += DEG_FULL;
        qtr = 2'(m / DEG_QUARTER);
        r = m - longint'(qtr) * DEG_QUARTER;
        z = (r * PI_Q32 + DEG_FULL) / (2 * DEG_FULL);
        x = round_shift((longint'($signed(p.px)) - longint'($signed(p.cx))) * gain_q30,
                        ANG_BITS - FRAC_N);
        y = round_shift((longint'($signed(p.py)) - longint'($signed(p.cy))) * gain_q30,
                        ANG_BITS - FRAC_N);
        case (qtr)
            QTR_ONE: begin
                t = x;
                x = -y;
                y = t;
            end
            QTR_HALF: begin
                x = -x;
                y = -y;
            end
            QTR_THREE: begin
                t = x;
                x = y;
                y = -t;
            end
            default: ;
        endcase
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= arctan_q30[i];
            end else begin
                x += ys;
                y -= xs;
                z += arctan_q30[i];
            end
        end
        res.sat = 1'b0;
        res.rx = clamp_coord(round_shift(x, FRAC_N) + longint'($signed(p.cx)), res.sat);
        res.ry = clamp_coord(round_shift(y, FRAC_N) + longint'($signed(p.cy)), res.sat);
        return res;
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(5))
            0: return MINC;
            1: return MAXC;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return ONE;
        endcase
    endfunction

    function automatic logic signed [16:0] random_angle();
        int sel;
        sel = $urandom_range(19);
        if (sel < 15) return 17'(int'($urandom_range(92160)) - 46080);
        // quarter-turn multiples with a one-step jitter
        if (sel < 18) return 17'((int'($urandom_range(8)) - 4) * 11520
                                 + int'($urandom_range(2)) - 1);
        return 17'($urandom);
    endfunction

    // Mostly offsets that stay in range, plus full-range noise, extremes and zero offsets
    function automatic pt_t random_point();
        int  sel;
        pt_t p;
        sel = $urandom_range(9);
        p.ang = random_angle();
        if (sel < 6) begin
            p.cx = 32'(int'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
            p.cy = 32'(int'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
            p.px = p.cx + 32'(int'($urandom_range(32'h1FFF_FFFF)) - 32'sh1000_0000);
            p.py = p.cy + 32'(int'($urandom_range(32'h1FFF_FFFF)) - 32'sh1000_0000);
        end else if (sel < 8) begin
            p.px = $urandom;
            p.py = $urandom;
            p.cx = $urandom;
            p.cy = $urandom;
        end else if (sel == 8) begin
            p.px = pick_extreme();
            p.py = pick_extreme();
            p.cx = pick_extreme();
            p.cy = pick_extreme();
        end else begin
            p.cx = $urandom;
            p.cy = $urandom;
            p.px = p.cx;
            p.py = p.cy;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_cnt < 100)
            $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
        mismatch_cnt++;
    endtask

    // Offer one beat after a random idle gap; queue its expectation on accept
    task automatic offer_point(input pt_t p, input logic has_want, input rot_t want);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({p.ang, p.cy, p.cx, p.py, p.px});
        do @(posedge aclk); while (!s_tready);
        pending_rot.push_back(has_want ? want : rotate_about_pivot(p));
    endtask

    // Receiver: long hold when requested, random stalls otherwise
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= aresetn && ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        rot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rot.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata[31:0], 0);
            end else begin
                want = pending_rot.pop_front();
                if ($signed(m_tdata[31:0]) != want.rx)
                    report_mismatch("rot_x", $signed(m_tdata[31:0]), want.rx);
                if ($signed(m_tdata[63:32]) != want.ry)
                    report_mismatch("rot_y", $signed(m_tdata[63:32]), want.ry);
                if (m_tdata[64] != want.sat)
                    report_mismatch("saturated", m_tdata[64], want.sat);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        longint unsigned acc, root, cand;
        longint          sum, term;

        // Gain correction: product of sqrt(1 + 4^-i), inverted in Q30
        acc = 64'd1 << 30;
        for (int i = 0; i < CORDIC_N; i++) acc += acc >> (2 * i);
        acc = acc << 30;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= acc) root = cand;
        end
        gain_q30 = longint'((64'd1 << 60) / root);

        // Arctangent of 2^-i from its series in Q60, rounded to Q30
        arctan_q30[0] = longint'(QUARTER_PI_Q30);
        for (int i = 1; i < CORDIC_N; i++) begin
            sum = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                term = (longint'(1) << (60 - i * (2 * k + 1))) / (2 * k + 1);
                sum += (k % 2 == 1) ? -term : term;
            end
            arctan_q30[i] = (sum + (longint'(1) << 29)) >>> 30;
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (int n = 0; n < DIR_N; n++)
            offer_point(DIRECTED[n].pt, DIRECTED[n].has_want, DIRECTED[n].want);

        // Random phases, two of them opening with a long receiver hold
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = IDLE_PCT[ph];
            stall_pct = STALL_PCT[ph];
            if (ph == 0 || ph == 3) begin
                hold_left = 300;
                repeat (80) offer_point(random_point(), 1'b0, NO_WANT);
            end
            repeat (370) offer_point(random_point(), 1'b0, NO_WANT);
        end

        // Drain
        idle_pct  = 0;
        stall_pct = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_rot.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
src/rpp_pkg.sv
src/rpp_prep.sv
src/rpp_cordic.sv
src/rpp_post.sv
src/rotate_point_about_pivot.sv
tb/tb_top.sv
